// ===== rtl/fsst_pkg.sv =====
// ============================================================================
// fsst_pkg - Shared definitions for the four sensor sun tracker stepper
// Holds register indexes, field widths, reset values, the half-step coil
// table and the structs passed between the front end, queue and back end.
// ============================================================================
package fsst_pkg;

    // Default sample width of each light sensor input.
    localparam int SAMPLE_BITS_DEFAULT = 12;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register field widths.
    localparam int THRESH_W   = 12;
    localparam int CONFIRM_W  = 4;
    localparam int INTERVAL_W = 8;
    localparam int STEPS_W    = 16;
    localparam int POS_W      = 2;
    localparam int PHASE_W    = 3;
    localparam int COIL_W     = 4;
    localparam int DIR_W      = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_MOVE_THRESHOLD     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_COUNT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_INTERVAL_MS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_TURN_STEPS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_TURN_STEPS    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_START_POSITION     = 3'd5;

    // Register reset values.
    localparam logic [THRESH_W-1:0]   MOVE_THRESHOLD_RST     = 12'd300;
    localparam logic [CONFIRM_W-1:0]  CONFIRM_COUNT_RST      = 4'd2;
    localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RST      = 8'd2;
    localparam logic [STEPS_W-1:0]    QUARTER_TURN_STEPS_RST = 16'd1024;
    localparam logic [STEPS_W-1:0]    HALF_TURN_STEPS_RST    = 16'd2048;
    localparam logic [POS_W-1:0]      START_POSITION_RST     = 2'd0;

    // Depth of the word queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Half-step coil patterns, bit 3 drives IN1 down to bit 0 driving IN4.
    localparam logic [COIL_W-1:0] COIL_TABLE [8] = '{
        4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1
    };

    // One classified pass, as handed from the front end to the back end.
    typedef struct packed {
        logic [POS_W-1:0] best;     // brightest sensor, lowest index on ties
        logic             lead_ok;  // lead over the runner-up reaches threshold
        logic             ms_tick;  // one millisecond elapsed before this pass
    } cls_t;

    // Motion settings used by the back end.
    typedef struct packed {
        logic [CONFIRM_W-1:0]  confirm_count;
        logic [INTERVAL_W-1:0] step_interval_ms;
        logic [STEPS_W-1:0]    quarter_turn_steps;
        logic [STEPS_W-1:0]    half_turn_steps;
    } motion_cfg_t;

    // Restore of the position from storage.
    typedef struct packed {
        logic             load;
        logic [POS_W-1:0] value;
    } pos_load_t;

endpackage

// ===== rtl/fsst_front.sv =====
// ============================================================================
// fsst_front - Input acceptance and light classification
// Picks the brightest sensor and the runner-up, checks the lead against the
// threshold and pushes the classified word into the queue.
// ============================================================================
module fsst_front #(
    parameter int SAMPLE_BITS = fsst_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SAMPLE_BITS-1:0]        light_br,
    input  logic [SAMPLE_BITS-1:0]        light_tr,
    input  logic [SAMPLE_BITS-1:0]        light_tl,
    input  logic [SAMPLE_BITS-1:0]        light_bl,
    input  logic                          ms_tick,
    input  logic [fsst_pkg::THRESH_W-1:0] move_threshold,
    input  logic                          queue_full,
    output logic                          push,
    output fsst_pkg::cls_t                push_word
);
    import fsst_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

    logic [SAMPLE_BITS-1:0] light [4];
    logic [SAMPLE_BITS-1:0] top;
    logic [SAMPLE_BITS-1:0] second;
    logic [POS_W-1:0]       best;
    logic [CMP_W-1:0]       lead;

    assign light[0] = light_br;
    assign light[1] = light_tr;
    assign light[2] = light_tl;
    assign light[3] = light_bl;

    // Brightest sensor; a later sensor must be strictly brighter to win.
    always_comb
    begin
        top  = light[0];
        best = '0;
        for (int i = 1; i < 4; i++)
        begin
            if (light[i] > top)
            begin
                top  = light[i];
                best = POS_W'(i);
            end
        end
    end

    // Runner-up is the brightest of the other three sensors.
    always_comb
    begin
        second = '0;
        for (int i = 0; i < 4; i++)
        begin
            if ((POS_W'(i) != best) && (light[i] > second))
            begin
                second = light[i];
            end
        end
    end

    assign lead = CMP_W'(top - second);

    assign in_stall          = queue_full;
    assign push              = in_valid & ~queue_full;
    assign push_word.best    = best;
    assign push_word.lead_ok = (lead >= CMP_W'(move_threshold));
    assign push_word.ms_tick = ms_tick;

endmodule

// ===== rtl/fsst_queue.sv =====
// ============================================================================
// fsst_queue - Short word queue between the front end and the back end
// A small circular buffer that lets either side stall on its own.
// ============================================================================
module fsst_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fsst_pkg::cls_t push_word,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output fsst_pkg::cls_t pop_word
);
    import fsst_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cls_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_word = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== rtl/fsst_back.sv =====
// ============================================================================
// fsst_back - Stepper drive and move decision
// Takes one classified word per cycle unless stalled, advances the half-step
// drive, decides moves and holds the result word until the consumer takes it.
// ============================================================================
module fsst_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             empty,
    input  fsst_pkg::cls_t                   pop_word,
    output logic                             pop,
    input  fsst_pkg::motion_cfg_t            motion_cfg,
    input  fsst_pkg::pos_load_t              pos_load,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fsst_pkg::COIL_W-1:0]      coil_pattern,
    output logic [fsst_pkg::POS_W-1:0]       position,
    output logic                             motor_busy,
    output logic                             move_pending,
    output logic                             position_saved
);
    import fsst_pkg::*;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

    localparam logic [POS_W-1:0] DIFF_CW  = 2'd1;
    localparam logic [POS_W-1:0] DIFF_CCW = 2'd3;

    // Motion state.
    logic [POS_W-1:0]      pos_reg,      pos_next;
    logic [DIR_W-1:0]      last_dir_reg, last_dir_next;
    logic [CONFIRM_W-1:0]  mismatch_reg, mismatch_next;
    logic                  moving_reg,   moving_next;
    logic                  rev_reg,      rev_next;
    logic [STEPS_W-1:0]    length_reg,   length_next;
    logic [STEPS_W-1:0]    steps_reg,    steps_next;
    logic [PHASE_W-1:0]    phase_reg,    phase_next;
    logic [INTERVAL_W-1:0] ms_reg,       ms_next;
    logic                  pend_reg,     pend_next;
    logic                  pend_rev_reg, pend_rev_next;
    logic [STEPS_W-1:0]    pend_len_reg, pend_len_next;
    logic [POS_W-1:0]      pend_tgt_reg, pend_tgt_next;
    logic [COIL_W-1:0]     coil_reg,     coil_next;
    logic                  saved_next;

    // Result word.
    logic                  out_valid_reg;
    logic [COIL_W-1:0]     out_coil_reg;
    logic [POS_W-1:0]      out_pos_reg;
    logic                  out_busy_reg;
    logic                  out_pend_reg;
    logic                  out_saved_reg;

    logic [POS_W-1:0]      diff;
    logic                  req_rev;
    logic [STEPS_W-1:0]    req_len;

    assign pop = ~empty & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        pos_next      = pos_reg;
        last_dir_next = last_dir_reg;
        mismatch_next = mismatch_reg;
        moving_next   = moving_reg;
        rev_next      = rev_reg;
        length_next   = length_reg;
        steps_next    = steps_reg;
        phase_next    = phase_reg;
        ms_next       = ms_reg;
        pend_next     = pend_reg;
        pend_rev_next = pend_rev_reg;
        pend_len_next = pend_len_reg;
        pend_tgt_next = pend_tgt_reg;
        coil_next     = coil_reg;
        saved_next    = 1'b0;
        diff          = '0;
        req_rev       = 1'b0;
        req_len       = '0;

        // Stepper advance.
        if (moving_reg)
        begin
            if (pop_word.ms_tick && (ms_reg != '1))
            begin
                ms_next = ms_reg + 1'b1;
            end
            if (ms_next >= motion_cfg.step_interval_ms)
            begin
                ms_next    = '0;
                phase_next = rev_reg ? phase_reg - 1'b1 : phase_reg + 1'b1;
                coil_next  = COIL_TABLE[phase_next];
                steps_next = steps_reg + 1'b1;
                if (steps_next >= length_reg)
                begin
                    moving_next = 1'b0;
                    if (pend_reg)
                    begin
                        moving_next = 1'b1;
                        rev_next    = pend_rev_reg;
                        length_next = pend_len_reg;
                        steps_next  = '0;
                        phase_next  = '0;
                        ms_next     = '0;
                        saved_next  = (pos_reg != pend_tgt_reg);
                        pos_next    = pend_tgt_reg;
                        pend_next   = 1'b0;
                    end
                end
            end
        end

        // Move decision on the position left by the stepper.
        if (pop_word.lead_ok)
        begin
            diff = pop_word.best - pos_next;
            if (diff == '0)
            begin
                mismatch_next = '0;
            end
            else
            begin
                if (diff == DIFF_CW)
                begin
                    req_rev = 1'b0;
                    req_len = motion_cfg.quarter_turn_steps;
                end
                else if (diff == DIFF_CCW)
                begin
                    req_rev = 1'b1;
                    req_len = motion_cfg.quarter_turn_steps;
                end
                else
                begin
                    req_rev = (last_dir_reg == DIR_FWD);
                    req_len = motion_cfg.half_turn_steps;
                end

                if (!moving_next)
                begin
                    if (mismatch_reg != '1)
                    begin
                        mismatch_next = mismatch_reg + 1'b1;
                    end
                    if (mismatch_next >= motion_cfg.confirm_count)
                    begin
                        moving_next   = 1'b1;
                        rev_next      = req_rev;
                        length_next   = req_len;
                        steps_next    = '0;
                        phase_next    = '0;
                        ms_next       = '0;
                        last_dir_next = req_rev ? DIR_REV : DIR_FWD;
                        pos_next      = pop_word.best;
                        saved_next    = 1'b1;
                        mismatch_next = '0;
                    end
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_rev_next = req_rev;
                    pend_len_next = req_len;
                    pend_tgt_next = pop_word.best;
                    mismatch_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= START_POSITION_RST;
            last_dir_reg  <= DIR_NONE;
            mismatch_reg  <= '0;
            moving_reg    <= 1'b0;
            rev_reg       <= 1'b0;
            length_reg    <= '0;
            steps_reg     <= '0;
            phase_reg     <= '0;
            ms_reg        <= '0;
            pend_reg      <= 1'b0;
            pend_rev_reg  <= 1'b0;
            pend_len_reg  <= '0;
            pend_tgt_reg  <= '0;
            coil_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pos_reg       <= pos_next;
                last_dir_reg  <= last_dir_next;
                mismatch_reg  <= mismatch_next;
                moving_reg    <= moving_next;
                rev_reg       <= rev_next;
                length_reg    <= length_next;
                steps_reg     <= steps_next;
                phase_reg     <= phase_next;
                ms_reg        <= ms_next;
                pend_reg      <= pend_next;
                pend_rev_reg  <= pend_rev_next;
                pend_len_reg  <= pend_len_next;
                pend_tgt_reg  <= pend_tgt_next;
                coil_reg      <= coil_next;
            end
            else if (pos_load.load)
            begin
                pos_reg <= pos_load.value;
            end

            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_coil_reg  <= coil_next;
            out_pos_reg   <= pos_next;
            out_busy_reg  <= moving_next;
            out_pend_reg  <= pend_next;
            out_saved_reg <= saved_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign coil_pattern   = out_coil_reg;
    assign position       = out_pos_reg;
    assign motor_busy     = out_busy_reg;
    assign move_pending   = out_pend_reg;
    assign position_saved = out_saved_reg;

endmodule

// ===== rtl/four_sensor_sun_tracker_stepper_core.sv =====
// ============================================================================
// four_sensor_sun_tracker_stepper_core - Sun tracker with half-step drive
// Turns passes of four light samples into coil patterns and position updates
// for a four-position tracker driven by an 8-phase half-step motor.
// ============================================================================
//
//  Channel   Handshake              Direction  Word contents
//  --------  ---------------------  ---------  ---------------------------------
//  in        in_valid / in_stall    input      light_br, light_tr, light_tl,
//                                              light_bl, ms_tick
//  out       out_valid / out_stall  output     coil_pattern, position,
//                                              motor_busy, move_pending,
//                                              position_saved
//  cfg       cfg_we                 input      cfg_index, cfg_data
//
// Every input word yields exactly one output word. The block sustains one
// word per cycle while the output is not stalled; an accepted word is
// registered first in the queue and then in the back end's output register,
// and a stalled output can hold it between the two. The back end's state
// update for each word sets that rate.
// Reset (rst_n low, asynchronous) loads the register defaults, stops the
// motor, turns all coils off and empties the queue.
// A stalled output holds its word; the two-entry queue fills behind it and
// in_stall rises only once the queue is full.
//
// The front end classifies each pass: it finds the brightest sensor (the
// lowest index wins ties) and whether its lead over the runner-up reaches
// move_threshold. The classified word then waits in the queue until the back
// end takes it. The back end first advances the stepper (millisecond count,
// phase index, step count, end of move and start of a queued move) and then
// acts on the classified word: it confirms a move while idle, or replaces
// the one queued move while busy.
//
// Writing start_position also loads the current position at once, as a
// restore from storage. Configuration is to be written only while the block
// is idle, so the front and back end see settled values; nothing enforces it.
// ============================================================================
module four_sensor_sun_tracker_stepper_core #(
    parameter int SAMPLE_BITS = fsst_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Configuration port
    input  logic                             cfg_we,
    input  logic [fsst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fsst_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [SAMPLE_BITS-1:0]           light_br,
    input  logic [SAMPLE_BITS-1:0]           light_tr,
    input  logic [SAMPLE_BITS-1:0]           light_tl,
    input  logic [SAMPLE_BITS-1:0]           light_bl,
    input  logic                             ms_tick,

    // Output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fsst_pkg::COIL_W-1:0]      coil_pattern,
    output logic [fsst_pkg::POS_W-1:0]       position,
    output logic                             motor_busy,
    output logic                             move_pending,
    output logic                             position_saved
);
    import fsst_pkg::*;

    // Configuration registers.
    logic [THRESH_W-1:0]   move_threshold_reg;
    logic [CONFIRM_W-1:0]  confirm_count_reg;
    logic [INTERVAL_W-1:0] step_interval_reg;
    logic [STEPS_W-1:0]    quarter_steps_reg;
    logic [STEPS_W-1:0]    half_steps_reg;

    motion_cfg_t motion_cfg;
    pos_load_t   pos_load;

    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    cls_t push_word;
    cls_t pop_word;

    // Register decode. The start position itself is only kept in the back
    // end's position register, so a write here only raises the load strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_threshold_reg <= MOVE_THRESHOLD_RST;
            confirm_count_reg  <= CONFIRM_COUNT_RST;
            step_interval_reg  <= STEP_INTERVAL_RST;
            quarter_steps_reg  <= QUARTER_TURN_STEPS_RST;
            half_steps_reg     <= HALF_TURN_STEPS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MOVE_THRESHOLD:     move_threshold_reg <= cfg_data[THRESH_W-1:0];
                REG_CONFIRM_COUNT:      confirm_count_reg  <= cfg_data[CONFIRM_W-1:0];
                REG_STEP_INTERVAL_MS:   step_interval_reg  <= cfg_data[INTERVAL_W-1:0];
                REG_QUARTER_TURN_STEPS: quarter_steps_reg  <= cfg_data[STEPS_W-1:0];
                REG_HALF_TURN_STEPS:    half_steps_reg     <= cfg_data[STEPS_W-1:0];
                default:                ;
            endcase
        end
    end

    assign pos_load.load  = cfg_we && (cfg_index == REG_START_POSITION);
    assign pos_load.value = cfg_data[POS_W-1:0];

    assign motion_cfg.confirm_count      = confirm_count_reg;
    assign motion_cfg.step_interval_ms   = step_interval_reg;
    assign motion_cfg.quarter_turn_steps = quarter_steps_reg;
    assign motion_cfg.half_turn_steps    = half_steps_reg;

    fsst_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .light_br       (light_br),
        .light_tr       (light_tr),
        .light_tl       (light_tl),
        .light_bl       (light_bl),
        .ms_tick        (ms_tick),
        .move_threshold (move_threshold_reg),
        .queue_full     (queue_full),
        .push           (push),
        .push_word      (push_word)
    );

    fsst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (queue_full),
        .pop       (pop),
        .empty     (queue_empty),
        .pop_word  (pop_word)
    );

    fsst_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (queue_empty),
        .pop_word       (pop_word),
        .pop            (pop),
        .motion_cfg     (motion_cfg),
        .pos_load       (pos_load),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .coil_pattern   (coil_pattern),
        .position       (position),
        .motor_busy     (motor_busy),
        .move_pending   (move_pending),
        .position_saved (position_saved)
    );

endmodule

// ===== rtl/fsst_checker.sv =====
// ============================================================================
// fsst_checker - Port-level checks for the sun tracker stepper core
// Watches the output channel for held words and consistent motion status.
// ============================================================================
module fsst_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [fsst_pkg::COIL_W-1:0] coil_pattern,
    input logic [fsst_pkg::POS_W-1:0]  position,
    input logic                        motor_busy,
    input logic                        move_pending,
    input logic                        position_saved
);
    import fsst_pkg::*;

    // A stalled word stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(coil_pattern)
            && $stable(position) && $stable(motor_busy)
            && $stable(move_pending) && $stable(position_saved))
    else $error("stalled output word changed");

    // A queued move only exists behind a running one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_pending |-> motor_busy)
    else $error("queued move reported with the motor stopped");

    // A saved position is only reported while a move is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && position_saved |-> motor_busy)
    else $error("position saved without a move in progress");

    // Half-step drive never energizes more than two adjacent coils.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones(coil_pattern) <= 2)
            && (coil_pattern != 4'b1010) && (coil_pattern != 4'b0101))
    else $error("coil pattern outside the half-step sequence");

endmodule

bind four_sensor_sun_tracker_stepper_core fsst_checker u_fsst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .coil_pattern   (coil_pattern),
    .position       (position),
    .motor_busy     (motor_busy),
    .move_pending   (move_pending),
    .position_saved (position_saved)
);

// ===== sim/fsst_tracker_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fsst_tracker_checker - Status word predictor and checker for the tracker
// Follows every accepted pass with its own copy of the stepper, queue and
// sensor logic, and compares each accepted status word with the oldest
// prediction. Hands the mismatch count and the number of words still due to
// the testbench top.
// ============================================================================
module fsst_tracker_checker #(
    parameter int SAMPLE_BITS = fsst_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fsst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fsst_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [SAMPLE_BITS-1:0]           light_br,
    input  logic [SAMPLE_BITS-1:0]           light_tr,
    input  logic [SAMPLE_BITS-1:0]           light_tl,
    input  logic [SAMPLE_BITS-1:0]           light_bl,
    input  logic                             ms_tick,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [fsst_pkg::COIL_W-1:0]      coil_pattern,
    input  logic [fsst_pkg::POS_W-1:0]       position,
    input  logic                             motor_busy,
    input  logic                             move_pending,
    input  logic                             position_saved,
    output int                               mismatch_count,
    output int                               status_pending
);
    import fsst_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Half-step sequence of the coil drive, IN1 in bit 3.
    localparam logic [COIL_W-1:0] HALF_STEP_COILS [8] = '{
        4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1
    };

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } move_dir_e;

    typedef struct packed {
        logic [COIL_W-1:0] coil;
        logic [POS_W-1:0]  pos;
        logic              busy;
        logic              pending;
        logic              saved;
    } status_t;

    // Register copies.
    logic [THRESH_W-1:0]   threshold;
    logic [CONFIRM_W-1:0]  confirm_needed;
    logic [INTERVAL_W-1:0] step_interval;
    logic [STEPS_W-1:0]    quarter_steps;
    logic [STEPS_W-1:0]    half_steps;

    // Tracker state.
    logic [POS_W-1:0]      aim_pos;
    move_dir_e             last_dir;
    logic [CONFIRM_W-1:0]  mismatch_run;
    logic                  moving;
    logic                  run_reverse;
    logic [STEPS_W-1:0]    run_length;
    logic [STEPS_W-1:0]    steps_taken;
    logic [PHASE_W-1:0]    phase;
    logic [INTERVAL_W-1:0] ms_count;
    logic                  queued;
    logic                  queued_reverse;
    logic [STEPS_W-1:0]    queued_length;
    logic [POS_W-1:0]      queued_target;
    logic [COIL_W-1:0]     coil_drive;

    status_t status_due [$];
    status_t predicted;
    status_t observed;

    task automatic launch_move(input logic reverse, input logic [STEPS_W-1:0] length);
        moving      = 1'b1;
        run_reverse = reverse;
        run_length  = length;
        steps_taken = '0;
        phase       = '0;
        ms_count    = '0;
    endtask

    // One pass: the stepper moves first, then the sensors are judged.
    task automatic track_pass(
        input  logic [SAMPLE_BITS-1:0] br,
        input  logic [SAMPLE_BITS-1:0] tr,
        input  logic [SAMPLE_BITS-1:0] tl,
        input  logic [SAMPLE_BITS-1:0] bl,
        input  logic                   tick,
        output status_t                st
    );
        logic [SAMPLE_BITS-1:0] light [4];
        logic [SAMPLE_BITS-1:0] top;
        logic [SAMPLE_BITS-1:0] second;
        logic [POS_W-1:0]       best;
        logic [POS_W-1:0]       diff;
        logic                   saved;
        logic                   reverse;
        logic [STEPS_W-1:0]     length;
        light[0] = br;
        light[1] = tr;
        light[2] = tl;
        light[3] = bl;
        saved = 1'b0;

        if (moving)
        begin
            if (tick && ms_count != 8'hFF)
                ms_count = ms_count + 1'b1;
            if (ms_count >= step_interval)
            begin
                ms_count    = '0;
                phase       = run_reverse ? phase - 3'd1 : phase + 3'd1;
                coil_drive  = HALF_STEP_COILS[phase];
                steps_taken = steps_taken + 1'b1;
                if (steps_taken >= run_length)
                begin
                    moving = 1'b0;
                    if (queued)
                    begin
                        launch_move(queued_reverse, queued_length);
                        if (aim_pos != queued_target)
                            saved = 1'b1;
                        aim_pos = queued_target;
                        queued  = 1'b0;
                    end
                end
            end
        end

        best = 2'd0;
        top  = light[0];
        for (int i = 1; i < 4; i++)
        begin
            if (light[i] > top)
            begin
                top  = light[i];
                best = POS_W'(i);
            end
        end
        second = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (POS_W'(i) != best && light[i] > second)
                second = light[i];
        end

        if (int'(top) - int'(second) >= int'(threshold))
        begin
            diff = best - aim_pos;
            if (diff == 2'd0)
                mismatch_run = '0;
            else
            begin
                if (diff == 2'd1)
                begin
                    reverse = 1'b0;
                    length  = quarter_steps;
                end
                else if (diff == 2'd3)
                begin
                    reverse = 1'b1;
                    length  = quarter_steps;
                end
                else
                begin
                    reverse = (last_dir == DIR_FWD);
                    length  = half_steps;
                end

                if (!moving)
                begin
                    if (mismatch_run != 4'hF)
                        mismatch_run = mismatch_run + 1'b1;
                    if (mismatch_run >= confirm_needed)
                    begin
                        launch_move(reverse, length);
                        last_dir     = reverse ? DIR_REV : DIR_FWD;
                        aim_pos      = best;
                        saved        = 1'b1;
                        mismatch_run = '0;
                    end
                end
                else
                begin
                    queued         = 1'b1;
                    queued_reverse = reverse;
                    queued_length  = length;
                    queued_target  = best;
                    mismatch_run   = '0;
                end
            end
        end

        st = '{coil_drive, aim_pos, moving, queued, saved};
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold      = MOVE_THRESHOLD_RST;
            confirm_needed = CONFIRM_COUNT_RST;
            step_interval  = STEP_INTERVAL_RST;
            quarter_steps  = QUARTER_TURN_STEPS_RST;
            half_steps     = HALF_TURN_STEPS_RST;
            aim_pos        = START_POSITION_RST;
            last_dir       = DIR_NONE;
            mismatch_run   = '0;
            moving         = 1'b0;
            run_reverse    = 1'b0;
            run_length     = '0;
            steps_taken    = '0;
            phase          = '0;
            ms_count       = '0;
            queued         = 1'b0;
            queued_reverse = 1'b0;
            queued_length  = '0;
            queued_target  = '0;
            coil_drive     = '0;
            status_due.delete();
            mismatch_count = 0;
            status_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MOVE_THRESHOLD:     threshold      = cfg_data[THRESH_W-1:0];
                    REG_CONFIRM_COUNT:      confirm_needed = cfg_data[CONFIRM_W-1:0];
                    REG_STEP_INTERVAL_MS:   step_interval  = cfg_data[INTERVAL_W-1:0];
                    REG_QUARTER_TURN_STEPS: quarter_steps  = cfg_data[STEPS_W-1:0];
                    REG_HALF_TURN_STEPS:    half_steps     = cfg_data[STEPS_W-1:0];
                    REG_START_POSITION:     aim_pos        = cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                track_pass(light_br, light_tr, light_tl, light_bl, ms_tick, predicted);
                status_due.push_back(predicted);
            end

            if (out_valid && !out_stall)
            begin
                observed = '{coil_pattern, position, motor_busy, move_pending, position_saved};
                if (status_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: status word with none expected, got %h",
                                 $realtime, observed);
                end
                else
                begin
                    predicted = status_due.pop_front();
                    check_field("coil_pattern", predicted.coil, observed.coil);
                    check_field("position", predicted.pos, observed.pos);
                    check_field("motor_busy", predicted.busy, observed.busy);
                    check_field("move_pending", predicted.pending, observed.pending);
                    check_field("position_saved", predicted.saved, observed.saved);
                end
            end

            status_pending = status_due.size();
        end
    end

endmodule

// ===== sim/tb_four_sensor_sun_tracker_stepper_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_four_sensor_sun_tracker_stepper_core - Testbench for the sun tracker core
// Feeds sensor passes through the input channel with random gaps and output
// stalls, walks the block through several register settings and leaves the
// checking of every status word to the checker beside the block.
// ============================================================================
module tb_four_sensor_sun_tracker_stepper_core;
    import fsst_pkg::*;

    localparam int SAMPLE_BITS     = SAMPLE_BITS_DEFAULT;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
    localparam int PHASES          = 8;
    localparam int PASSES_PER_PHASE = 100;
    // No phase of the run leaves both channels quiet for long: the longest
    // quiet spell is a register update or the settling wait.
    localparam int QUIET_LIMIT     = 2000;
    // Extra wait after the last status word has been checked.
    localparam int SETTLE_CYCLES   = 8;

    logic clk = 1'b0;
    logic rst_n;

    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic                   in_valid;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] light_br;
    logic [SAMPLE_BITS-1:0] light_tr;
    logic [SAMPLE_BITS-1:0] light_tl;
    logic [SAMPLE_BITS-1:0] light_bl;
    logic                   ms_tick;

    logic                   out_valid;
    logic                   out_stall;
    logic [COIL_W-1:0]      coil_pattern;
    logic [POS_W-1:0]       position;
    logic                   motor_busy;
    logic                   move_pending;
    logic                   position_saved;

    int mismatch_count;
    int status_pending;
    int quiet_cycles;

    // Stimulus state: idling switch, the threshold in force and the sensor
    // the random light scenes currently favor.
    logic steady;
    int   active_threshold;
    int   favored;

    always #4 clk = ~clk;

    four_sensor_sun_tracker_stepper_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .light_br      (light_br),
        .light_tr      (light_tr),
        .light_tl      (light_tl),
        .light_bl      (light_bl),
        .ms_tick       (ms_tick),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coil_pattern  (coil_pattern),
        .position      (position),
        .motor_busy    (motor_busy),
        .move_pending  (move_pending),
        .position_saved(position_saved)
    );

    fsst_tracker_checker #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) tracker_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .light_br      (light_br),
        .light_tr      (light_tr),
        .light_tl      (light_tl),
        .light_bl      (light_bl),
        .ms_tick       (ms_tick),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coil_pattern  (coil_pattern),
        .position      (position),
        .motor_busy    (motor_busy),
        .move_pending  (move_pending),
        .position_saved(position_saved),
        .mismatch_count(mismatch_count),
        .status_pending(status_pending)
    );

    // The output side stalls at random with a chance of 11 in a hundred, except
    // while the steady stretch runs.
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 11);

    // The watchdog counts cycles in which neither channel moves a word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Offers one pass on the input channel and returns at the clock edge that
    // takes it. Random gaps come first, with valid low. The stall is looked
    // at on the falling edge, where it has settled for the coming rising edge.
    task automatic send_pass(
        input logic [SAMPLE_BITS-1:0] br,
        input logic [SAMPLE_BITS-1:0] tr,
        input logic [SAMPLE_BITS-1:0] tl,
        input logic [SAMPLE_BITS-1:0] bl,
        input logic                   tick
    );
        logic taken;
        while (!steady && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        light_br <= br;
        light_tr <= tr;
        light_tl <= tl;
        light_bl <= bl;
        ms_tick  <= tick;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
    endtask

    // Drops valid and waits until every predicted status word has been
    // checked, then lets the pipeline settle so the block is truly idle.
    task automatic wait_for_status();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            @(negedge clk);
        end
        while (status_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all six registers on back-to-back cycles. Writing the start
    // position also moves the current position, like a restore from storage.
    task automatic configure(
        input int threshold,
        input int confirm,
        input int interval,
        input int quarter,
        input int half,
        input int start
    );
        int values [6];
        logic [CFG_INDEX_W-1:0] regs [6];
        values = '{threshold, confirm, interval, quarter, half, start};
        regs   = '{REG_MOVE_THRESHOLD, REG_CONFIRM_COUNT, REG_STEP_INTERVAL_MS,
                   REG_QUARTER_TURN_STEPS, REG_HALF_TURN_STEPS, REG_START_POSITION};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= CFG_DATA_W'(values[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        active_threshold = threshold;
    endtask

    // Builds one random light scene. Most scenes have a clear leader with a
    // lead at or above the threshold, and the leader stays the same for runs
    // of passes so that moves get confirmed, queued and replaced. The rest
    // are ties, weak leads and unstructured noise.
    task automatic random_pass();
        int v [4];
        int kind;
        int lead;
        int peak;
        int floor_level;
        int other;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 20)
            favored = $urandom_range(0, 3);
        if (kind < 65)
        begin
            lead = active_threshold + $urandom_range(0, 40);
            if (lead > SAMPLE_MAX)
                lead = SAMPLE_MAX;
            peak = $urandom_range(lead, SAMPLE_MAX);
            for (int i = 0; i < 4; i++)
                v[i] = $urandom_range(0, peak - lead);
            v[favored] = peak;
        end
        else if (kind < 75)
        begin
            // Two sensors share the top reading; the lower index must win.
            peak = $urandom_range(0, SAMPLE_MAX);
            for (int i = 0; i < 4; i++)
                v[i] = $urandom_range(0, peak);
            other = (favored + 1 + $urandom_range(0, 2)) % 4;
            v[favored] = peak;
            v[other]   = peak;
        end
        else if (kind < 85)
        begin
            // Lead below a nonzero threshold: no move decision may follow.
            peak = $urandom_range(0, SAMPLE_MAX);
            floor_level = (active_threshold == 0) ? peak : peak - (active_threshold - 1);
            if (floor_level < 0)
                floor_level = 0;
            for (int i = 0; i < 4; i++)
                v[i] = $urandom_range(floor_level, peak);
            v[favored] = peak;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                v[i] = $urandom_range(0, SAMPLE_MAX);
                if ($urandom_range(0, 3) == 0)
                    v[i] = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            end
        end
        send_pass(SAMPLE_BITS'(v[0]), SAMPLE_BITS'(v[1]), SAMPLE_BITS'(v[2]),
                  SAMPLE_BITS'(v[3]), $urandom_range(0, 99) < 75);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        light_br  = '0;
        light_tr  = '0;
        light_tl  = '0;
        light_bl  = '0;
        ms_tick   = 1'b0;
        out_stall = 1'b0;
        steady    = 1'b0;
        favored   = 0;
        active_threshold = int'(MOVE_THRESHOLD_RST);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed passes under the reset settings: lead of 300, two
        // confirming passes, long moves that stay busy throughout.
        send_pass(0, 0, 0, 0, 1'b0);                     // all dark, four-way tie
        send_pass(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1); // all saturated
        send_pass(SAMPLE_MAX, 0, 0, 0, 1'b1);            // already facing BR
        send_pass(0, SAMPLE_MAX, 0, 0, 1'b1);            // first request toward TR
        send_pass(0, SAMPLE_MAX, 0, 0, 1'b1);            // confirmed, quarter turn starts
        send_pass(0, 0, SAMPLE_MAX, 0, 1'b1);            // busy, move to TL is queued
        send_pass(0, 0, 0, SAMPLE_MAX, 1'b0);            // queued move replaced, half turn
        send_pass(1000, 1200, 900, 0, 1'b1);             // lead of 200 is too weak
        send_pass(2000, 2000, 0, 0, 1'b1);               // tie between BR and TR
        send_pass(SAMPLE_MAX, SAMPLE_MAX - 300, 0, 0, 1'b1); // lead exactly on threshold

        // Lowest register values: every pass is a strong lead, moves start at
        // once, step on every pass and end after their first step.
        wait_for_status();
        configure(0, 0, 0, 0, 0, 3);
        send_pass(0, 0, 0, 0, 1'b1);                     // tie counts as a lead of zero
        send_pass(0, 0, 0, 0, 1'b0);                     // zero-length move ends
        send_pass(0, 0, SAMPLE_MAX, 0, 1'b0);            // half turn after a forward move
        send_pass(0, SAMPLE_MAX, 0, 0, 1'b1);            // quarter turn backward
        send_pass(SAMPLE_MAX, 0, 0, 0, 1'b1);
        send_pass(0, 0, 0, SAMPLE_MAX, 1'b0);
        send_pass(0, 0, SAMPLE_MAX, 0, 1'b1);            // another quarter turn backward
        send_pass(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);

        // Random phases. The first uses the highest register values, the
        // rest short moves and small intervals so that moves finish, queued
        // moves start and coils cycle through all phases. One phase runs
        // without any idling on either side.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_for_status();
            if (ph == 0)
                configure(SAMPLE_MAX, 15, 255, 65535, 65535, 1);
            else if (ph == 1)
                configure(1, 1, 1, 1, 2, 2);
            else
                configure($urandom_range(0, 600), $urandom_range(0, 4),
                          $urandom_range(0, 3), $urandom_range(0, 12),
                          $urandom_range(0, 24), $urandom_range(0, 3));
            steady <= (ph == 4);
            repeat (PASSES_PER_PHASE) random_pass();
        end

        wait_for_status();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
